// ===== rtl/clsr_pkg.sv =====
// ----------------------------------------------------------------------------
// clsr_pkg
// Shared types, constants and the modular fold for the combined congruential
// generator with shuffle table.
// ----------------------------------------------------------------------------
package clsr_pkg;

  // generator moduli are 2^31 minus a small fold constant
  localparam logic [30:0] MOD_ONE        = 31'd2147483563;
  localparam logic [30:0] MOD_TWO        = 31'd2147483399;
  localparam logic [15:0] MUL_ONE        = 16'd40014;
  localparam logic [15:0] MUL_TWO        = 16'd40692;
  localparam logic [7:0]  FOLD_ONE       = 8'd85;
  localparam logic [7:0]  FOLD_TWO       = 8'd249;
  localparam logic [30:0] SPAN_ONE       = 31'd2147483562;
  localparam logic [30:0] SEED_TWO_RESET = 31'd123456789;
  localparam int          WARMUP         = 8;

  typedef enum logic {
    OP_DRAW,
    OP_RESEED
  } op_t;

  typedef enum logic {
    GEN_ONE,
    GEN_TWO
  } gen_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_ISSUE,
    ST_SEED_WAIT,
    ST_DRAW_INIT,
    ST_DRAW_DIV,
    ST_DRAW_READ,
    ST_DRAW_DONE
  } state_t;

  // final fold: r < 2^31 + 2^24, returns r mod (2^31 - c)
  function automatic logic [30:0] mod_fold(input logic [31:0] r, input logic [7:0] c);
    logic [31:0] t;
    t = {1'b0, r[30:0]} + {24'b0, c};
    if (r[31] || t[31]) begin
      return t[30:0];
    end else begin
      return r[30:0];
    end
  endfunction

endpackage

// ===== rtl/combined_lcg_shuffle_rng_top.sv =====
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_top
// Combined multiplicative congruential generator pair with a shuffle table,
// built around one shared three-stage modular multiplier and a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------
//  in      | in_valid  | in_stall  | operation, seed_value
//  out     | out_valid | out_stall | random_value
//
//  A plain draw steps the first and then the second generator through the
//  three-stage multiplier, the second issued in the cycle after the first,
//  while the slot estimate and its correction run alongside; then the table
//  is accessed and the result formed and loaded.
//  A reseed first runs the warm-up chain of TABLE_SIZE+WARMUP steps through the
//  three-stage multiplier, one step at a time.
//  in_stall is high during reset and from acceptance until the result is
//  loaded; a result held by out_stall does not block the next request, only
//  its completion.
//  Synchronous reset restores the generator states and empties the table.
//
module combined_lcg_shuffle_rng_top #(
  parameter int TABLE_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [30:0] seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] random_value
);
  import clsr_pkg::*;

  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int QW  = $clog2(TABLE_SIZE + 1);
  localparam int SW  = $clog2(TABLE_SIZE + WARMUP);
  localparam int RS  = 40;
  localparam logic [30:0] SLOT_DIV   = 31'(1 + SPAN_ONE / TABLE_SIZE);
  localparam logic [15:0] SLOT_RECIP = 16'((64'd1 << RS) / 64'(SLOT_DIV));

  state_t state, state_next;

  logic [30:0] first, second, last_output;
  logic [SW-1:0] step;

  // slot index: reciprocal estimate, then one compare and subtract
  logic [46:0]   recip_prod;
  logic [31:0]   quo_mul;
  logic [31:0]   rem_est;
  logic [QW-1:0] quo_est;
  logic [QW-1:0] quo;
  logic [1:0]    cnt;
  logic [AW-1:0] slot;

  // shared multiplier pipeline
  logic        v1, v2;
  gen_sel_t    sel1, sel2;
  logic [46:0] p1;
  logic [31:0] r2;
  logic [30:0] wb_res;

  // table
  logic [30:0]           mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld_bits;
  logic [30:0]           rd_data;
  logic                  rd_hit;
  logic [30:0]           entry;

  // sequencer outputs
  logic        accept, reseed, seed_load, iss_vld, div_load, div_step;
  logic        mem_we, rd_en, lo_from_res, out_load;
  gen_sel_t    iss_sel;
  logic [AW-1:0] mem_wa;
  logic [30:0] mem_wd, seed_eff, iss_op, draw_value;
  logic [15:0] iss_mul;
  logic [7:0]  fold_c;
  logic [23:0] fold_prod;
  logic [32:0] diff_raw, diff_adj;

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // a plain draw with the first generator stuck at zero reseeds from one
  assign reseed   = (operation == OP_RESEED) || (first == '0);
  assign seed_eff = ((operation == OP_RESEED) && (seed_value != '0)) ? seed_value : 31'd1;

  assign slot = (quo >= QW'(TABLE_SIZE)) ? AW'(TABLE_SIZE - 1) : quo[AW-1:0];

  always_comb begin
    state_next  = state;
    seed_load   = 1'b0;
    iss_vld     = 1'b0;
    iss_sel     = GEN_ONE;
    div_load    = 1'b0;
    div_step    = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = slot;
    mem_wd      = first;
    rd_en       = 1'b0;
    lo_from_res = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          seed_load  = reseed;
          state_next = reseed ? ST_SEED_ISSUE : ST_DRAW_INIT;
        end
      end
      ST_SEED_ISSUE: begin
        iss_vld    = 1'b1;
        state_next = ST_SEED_WAIT;
      end
      ST_SEED_WAIT: begin
        if (v2) begin
          mem_we = (step < SW'(TABLE_SIZE));
          mem_wa = step[AW-1:0];
          mem_wd = wb_res;
          if (step == '0) begin
            lo_from_res = 1'b1;
            state_next  = ST_DRAW_INIT;
          end else begin
            state_next = ST_SEED_ISSUE;
          end
        end
      end
      ST_DRAW_INIT: begin
        div_load   = 1'b1;
        iss_vld    = 1'b1;
        state_next = ST_DRAW_DIV;
      end
      ST_DRAW_DIV: begin
        div_step = 1'b1;
        if (cnt == 2'd0) begin
          iss_vld = 1'b1;
          iss_sel = GEN_TWO;
        end
        // wait for the second generator step to land
        if (cnt == 2'd2) begin
          state_next = ST_DRAW_READ;
        end
      end
      ST_DRAW_READ: begin
        // old entry is read out while the new first state goes in
        rd_en      = 1'b1;
        mem_we     = 1'b1;
        state_next = ST_DRAW_DONE;
      end
      ST_DRAW_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // multiplier stage one: 31 x 16 product
  assign iss_op  = (iss_sel == GEN_ONE) ? first : second;
  assign iss_mul = (iss_sel == GEN_ONE) ? MUL_ONE : MUL_TWO;

  // stage two: fold the bits above 2^31 back in
  assign fold_c    = (sel1 == GEN_ONE) ? FOLD_ONE : FOLD_TWO;
  assign fold_prod = 24'(p1[46:31]) * 24'(fold_c);

  // stage three: final fold and write-back
  assign wb_res = mod_fold(r2, (sel2 == GEN_ONE) ? FOLD_ONE : FOLD_TWO);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= iss_vld;
      v2 <= v1;
    end
    sel1 <= iss_sel;
    sel2 <= sel1;
    p1   <= 47'(iss_op) * 47'(iss_mul);
    r2   <= {1'b0, p1[30:0]} + {8'b0, fold_prod};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first  <= 31'd1;
      second <= SEED_TWO_RESET;
    end else if (seed_load) begin
      first  <= seed_eff;
      second <= seed_eff;
    end else if (v2) begin
      if (sel2 == GEN_ONE) begin
        first <= wb_res;
      end else begin
        second <= wb_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_output <= '0;
    end else if (lo_from_res) begin
      last_output <= wb_res;
    end else if (out_load) begin
      last_output <= draw_value;
    end
  end

  always_ff @(posedge clk) begin
    if (seed_load) begin
      step <= SW'(TABLE_SIZE + WARMUP - 1);
    end else if (state == ST_SEED_WAIT && v2 && step != '0) begin
      step <= step - 1'b1;
    end
  end

  // estimate is low by at most one, the remainder check settles it
  assign recip_prod = {16'b0, last_output} * {31'b0, SLOT_RECIP};
  assign quo_mul    = 32'(quo_est) * 32'(SLOT_DIV);
  assign rem_est    = {1'b0, last_output} - quo_mul;

  always_ff @(posedge clk) begin
    if (div_load) begin
      quo_est <= recip_prod[RS +: QW];
      cnt     <= '0;
    end else if (div_step) begin
      if (cnt == 2'd0) begin
        quo <= quo_est + QW'(rem_est >= {1'b0, SLOT_DIV});
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= mem[slot];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_bits <= '0;
      rd_hit   <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_hit <= vld_bits[slot];
      end
      if (mem_we) begin
        vld_bits[mem_wa] <= 1'b1;
      end
    end
  end

  assign entry      = rd_hit ? rd_data : '0;
  assign diff_raw   = {2'b00, entry} - {2'b00, second};
  assign diff_adj   = (diff_raw[32] || diff_raw == '0) ? diff_raw + {2'b00, SPAN_ONE} : diff_raw;
  assign draw_value = diff_adj[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      random_value <= draw_value;
    end
  end

  // both generator steps must have landed before the table access
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW_READ) |-> (!v1 && !v2))
    else $error("multiplier pipeline busy at table access");

  assert property (@(posedge clk) disable iff (rst)
    (v2 && sel2 == GEN_ONE) |-> (wb_res < MOD_ONE))
    else $error("first generator result not reduced");

  assert property (@(posedge clk) disable iff (rst)
    (v2 && sel2 == GEN_TWO) |-> (wb_res < MOD_TWO))
    else $error("second generator result not reduced");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW_READ) |-> (quo <= QW'(TABLE_SIZE)))
    else $error("slot quotient out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (draw_value != '0 && draw_value <= SPAN_ONE))
    else $error("draw outside output range");

endmodule

// ===== sim/combined_lcg_shuffle_rng_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_top_tb
// Self-checking bench for the combined congruential generator with shuffle
// table. Each accepted request is run through a behavioural model of both
// generators and the table. The expected draw is queued and compared with
// each result taken from the output channel. The sender works in bursts and
// the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_top_tb;

  import clsr_pkg::*;

  localparam int          TABLE_SLOTS  = 32;
  localparam logic [30:0] SLOT_SPAN    = 31'(SPAN_ONE / TABLE_SLOTS + 1);
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          TAIL_CYCLES  = 3 * (TABLE_SLOTS + WARMUP) + 40;
  localparam int          RANDOM_COUNT = 930;
  localparam int          REPORT_LIMIT = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_DRAW;
  logic [30:0] seed_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] random_value;

  // behavioural copy of the generator state
  logic [30:0] gen_one_state;
  logic [30:0] gen_two_state;
  logic [30:0] last_draw;
  logic [30:0] shuffle_slots [TABLE_SLOTS];

  logic [30:0] pending_draws [$];

  int cycle_count;
  int failures;
  int burst_left;
  int reseeds_sent;
  int draws_sent;
  int zero_state_draws;
  int draws_checked;
  int stall_left;
  int stall_mode;

  combined_lcg_shuffle_rng_top #(
    .TABLE_SIZE(TABLE_SLOTS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .seed_value  (seed_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_value(random_value)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [30:0] lcg_mulmod(input logic [30:0] s, input logic [15:0] a,
                                             input logic [30:0] m);
    logic [63:0] prod;
    prod = {33'b0, s} * {48'b0, a};
    return 31'(prod % {33'b0, m});
  endfunction

  function automatic void model_reset();
    gen_one_state = 31'd1;
    gen_two_state = SEED_TWO_RESET;
    last_draw     = '0;
    foreach (shuffle_slots[i]) shuffle_slots[i] = '0;
  endfunction

  function automatic void model_reseed(input logic [30:0] seed);
    if (seed == '0) seed = 31'd1;
    gen_one_state = seed;
    gen_two_state = seed;
    // warm-up steps are thrown away, the rest fill the table top down
    for (int j = TABLE_SLOTS + WARMUP - 1; j >= 0; j--) begin
      gen_one_state = lcg_mulmod(gen_one_state, MUL_ONE, MOD_ONE);
      if (j < TABLE_SLOTS) shuffle_slots[j] = gen_one_state;
    end
    last_draw = shuffle_slots[0];
  endfunction

  function automatic logic [30:0] model_draw();
    int unsigned slot;
    longint      diff;
    gen_one_state = lcg_mulmod(gen_one_state, MUL_ONE, MOD_ONE);
    gen_two_state = lcg_mulmod(gen_two_state, MUL_TWO, MOD_TWO);
    slot = last_draw / SLOT_SPAN;
    if (slot >= TABLE_SLOTS) slot = TABLE_SLOTS - 1;
    diff = longint'({33'b0, shuffle_slots[slot]}) - longint'({33'b0, gen_two_state});
    shuffle_slots[slot] = gen_one_state;
    if (diff < 1) diff += longint'({33'b0, SPAN_ONE});
    last_draw = diff[30:0];
    return last_draw;
  endfunction

  function automatic logic [30:0] predict_request(input op_t op, input logic [30:0] seed);
    if (op == OP_RESEED) begin
      model_reseed(seed);
    end else if (gen_one_state == '0) begin
      // first generator stuck at zero: recovers as if seeded with one
      zero_state_draws++;
      model_reseed(31'd1);
    end
    return model_draw();
  endfunction

  // ---------------------------------------------------------------- sender

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    // some bursts follow straight on
    if ($urandom_range(0, 3) == 0) return;
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  task automatic send_request(input op_t op, input logic [30:0] seed);
    in_valid   <= 1'b1;
    operation  <= op;
    seed_value <= seed;
    do @(posedge clk); while (in_stall);
    if (op == OP_RESEED) reseeds_sent++;
    else draws_sent++;
    pending_draws.push_back(predict_request(op, seed));
    pace_sender();
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  function automatic logic [30:0] pick_seed();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 31'($urandom());
    if (pick < 70) return 31'($urandom_range(0, 1000));
    if (pick < 80) return 31'($urandom_range(MOD_ONE - 64, MOD_ONE + 64));
    if (pick < 90) return 31'($urandom_range(MOD_TWO - 64, MOD_TWO + 64));
    if (pick < 95) return 31'($urandom_range(31'h7fff_ffc0, 31'h7fff_ffff));
    return MOD_ONE;
  endfunction

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 300);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall <= (cycle_count % 16) < 5;
      end
      default: begin
        out_stall <= ($urandom_range(0, 9) < 7);
      end
    endcase
  end

  // ---------------------------------------------------------------- checking

  function automatic void log_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    logic [30:0] wanted;
    if (!rst && out_valid && !out_stall) begin
      if (pending_draws.size() == 0) begin
        log_failure($sformatf("result %0d with no request outstanding", random_value));
      end else begin
        wanted = pending_draws.pop_front();
        draws_checked++;
        if (random_value !== wanted) begin
          log_failure($sformatf("random_value expected %0d got %0d", wanted, random_value));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d draws outstanding", cycle_count,
               pending_draws.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_draws_after_reset();
    // table still all zeros, no seed applied
    repeat (3) send_request(OP_DRAW, 31'($urandom()));
  endtask

  task automatic test_seed_extremes();
    send_request(OP_RESEED, 31'd0);
    send_request(OP_DRAW, 31'h7fff_ffff);
    send_request(OP_RESEED, 31'd1);
    send_request(OP_RESEED, MOD_TWO - 31'd1);
    send_request(OP_RESEED, MOD_TWO);
    send_request(OP_RESEED, MOD_TWO + 31'd1);
    send_request(OP_RESEED, MOD_ONE - 31'd1);
    send_request(OP_RESEED, MOD_ONE + 31'd1);
    send_request(OP_RESEED, 31'h7fff_ffff);
    send_request(OP_DRAW, 31'd0);
    send_request(OP_RESEED, 31'h2aaa_aaaa);
    send_request(OP_RESEED, 31'h5555_5555);
  endtask

  task automatic test_zero_state_recovery();
    // seeding with the first modulus leaves the first generator at zero
    send_request(OP_RESEED, MOD_ONE);
    send_request(OP_DRAW, 31'($urandom()));
    send_request(OP_DRAW, 31'($urandom()));
    send_request(OP_DRAW, 31'($urandom()));
  endtask

  task automatic test_drained_pause();
    send_request(OP_DRAW, 31'($urandom()));
    send_request(OP_RESEED, 31'($urandom()));
    wait_until_drained();
    send_request(OP_DRAW, 31'($urandom()));
  endtask

  task automatic test_random_stream(input int n_requests);
    int sent;
    int run_len;
    int next_pause;
    sent       = 0;
    next_pause = 300;
    while (sent < n_requests) begin
      if ($urandom_range(0, 99) < 80) begin
        // reseed followed by a run of draws
        send_request(OP_RESEED, pick_seed());
        run_len = $urandom_range(1, 30);
        repeat (run_len) send_request(OP_DRAW, 31'($urandom()));
        sent += run_len + 1;
      end else begin
        // loose mix of requests
        run_len = $urandom_range(1, 6);
        repeat (run_len) send_request(op_t'($urandom_range(0, 1)), pick_seed());
        sent += run_len;
      end
      if (sent >= next_pause) begin
        wait_until_drained();
        next_pause += 300;
      end
    end
  endtask

  initial begin
    model_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_draws_after_reset();
    test_seed_extremes();
    test_zero_state_recovery();
    test_drained_pause();
    test_random_stream(RANDOM_COUNT);
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_draws.size() != 0) begin
      log_failure($sformatf("%0d expected draws never arrived", pending_draws.size()));
    end
    $display("requests: %0d reseeds, %0d plain draws (%0d from a zero first state)",
             reseeds_sent, draws_sent, zero_state_draws);
    $display("draws checked: %0d, failures: %0d", draws_checked, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
